@@ rtl/hsi_pkg.sv @@
package hsi_pkg;

    localparam int CHAN_W     = 8;
    localparam int SUM_W      = 10;
    localparam int HUE_W      = 16;
    localparam int SAT_W      = 16;
    localparam int SAT_FRAC   = 15;
    localparam int CORDIC_N   = 30;
    localparam int IDX_W      = 5;
    localparam int FRAC_Q     = 40;
    // vector magnitude (CORDIC gain included) stays below 2^51 in Q40; bit 51 is the sign
    localparam int VEC_W      = 52;
    localparam int ACC_W      = 32;
    localparam int DIV_STEPS  = 16;
    localparam int REM_W      = SUM_W + SAT_FRAC + 1;
    localparam logic [40:0] SQRT3_Q40 = 41'd1904410002821;

    typedef struct packed {
        logic                     valid;
        logic signed [VEC_W-1:0]  x;
        logic signed [VEC_W-1:0]  y;
        logic [ACC_W-1:0]         acc;
        logic [REM_W-1:0]         rem;
        logic [SAT_W-1:0]         quo;
        logic [SUM_W-1:0]         sum;
        logic                     grey;
        logic                     black;
    } stage_t;

    function automatic logic [ACC_W-1:0] atan_turn(input logic [IDX_W-1:0] i);
        logic [ACC_W-1:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/hsi_stage.sv @@
// One CORDIC vectoring iteration plus, in the first stages, one quotient bit.
module hsi_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        ce,
    input  logic [hsi_pkg::IDX_W-1:0]   idx,
    input  hsi_pkg::stage_t             stage_in,
    output hsi_pkg::stage_t             stage_out
);

    hsi_pkg::stage_t                     st_reg, st_next;
    logic signed [hsi_pkg::VEC_W-1:0]    xs, ys;
    logic [hsi_pkg::REM_W-1:0]           dsh;
    logic [3:0]                          qbit;

    always_comb begin
        st_next = stage_in;
        xs = stage_in.x >>> idx;
        ys = stage_in.y >>> idx;
        if (!stage_in.y[hsi_pkg::VEC_W-1]) begin
            st_next.x   = stage_in.x + ys;
            st_next.y   = stage_in.y - xs;
            st_next.acc = stage_in.acc + hsi_pkg::atan_turn(idx);
        end else begin
            st_next.x   = stage_in.x - ys;
            st_next.y   = stage_in.y + xs;
            st_next.acc = stage_in.acc - hsi_pkg::atan_turn(idx);
        end
        // restoring divide, MSB first: quotient bit 15-idx
        qbit = 4'd15 - idx[3:0];
        dsh  = {{(hsi_pkg::REM_W-hsi_pkg::SUM_W-1){1'b0}}, stage_in.sum, 1'b0} << qbit;
        if (idx < hsi_pkg::IDX_W'(hsi_pkg::DIV_STEPS) && stage_in.rem >= dsh) begin
            st_next.rem        = stage_in.rem - dsh;
            st_next.quo[qbit]  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (ce) begin
            st_reg.valid <= stage_in.valid;
        end
        if (ce) begin
            st_reg.x     <= st_next.x;
            st_reg.y     <= st_next.y;
            st_reg.acc   <= st_next.acc;
            st_reg.rem   <= st_next.rem;
            st_reg.quo   <= st_next.quo;
            st_reg.sum   <= st_next.sum;
            st_reg.grey  <= st_next.grey;
            st_reg.black <= st_next.black;
        end
    end

    assign stage_out = st_reg;

endmodule

@@ rtl/rgb_to_hsi_pixel.sv @@
// Channel  | Dir | Ports                        | Contents
// s_axis   | in  | s_axis_tvalid/tready/tdata   | chan_r, chan_g, chan_b
// m_axis   | out | m_axis_tvalid/tready/tdata   | hue_turn, sat_q15, intensity_sum
//
// The pipe is a pre-processing register, a setup register
// (sign fold and sqrt(3) scaling), 30 CORDIC stages, and the output register.
// Throughput is one pixel per clock while m_axis does not stall; the 30-stage CORDIC chain sets the depth.
// aresetn (synchronous) clears only the valid bits along the pipe.
// A stall on m_axis freezes every stage together; nothing is dropped or repeated.
module rgb_to_hsi_pixel (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // chan_r[7:0], chan_g[15:8], chan_b[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // hue_turn[15:0], sat_q15[31:16],
                                        // intensity_sum[41:32], zero pad[47:42]
);

    // global advance: move when the output slot is free or being taken
    logic ce;
    assign ce = m_axis_tready | ~m_axis_tvalid;
    assign s_axis_tready = ce;

    // ---- stage 0: sum, min, differences
    logic [hsi_pkg::CHAN_W-1:0] r, g, b, mn;
    assign r = s_axis_tdata[7:0];
    assign g = s_axis_tdata[15:8];
    assign b = s_axis_tdata[23:16];
    always_comb begin
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
    end

    logic                        v0_reg;
    logic [hsi_pkg::SUM_W-1:0]   sum0_reg;
    logic [hsi_pkg::SUM_W-1:0]   sat_num0_reg;   // sum - 3*min
    logic signed [10:0]          dx0_reg;
    logic signed [8:0]           dy0_reg;
    logic                        grey0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (ce) begin
            v0_reg <= s_axis_tvalid;
        end
        if (ce) begin
            sum0_reg     <= 10'(r) + 10'(g) + 10'(b);
            sat_num0_reg <= 10'(r) + 10'(g) + 10'(b) - 10'(mn) - 10'(mn) - 10'(mn);
            dx0_reg      <= $signed({2'b00, r, 1'b0}) - $signed({3'b000, g})
                            - $signed({3'b000, b});
            dy0_reg      <= $signed({1'b0, g}) - $signed({1'b0, b});
            grey0_reg    <= (r == g) && (r == b);
        end
    end

    // ---- stage 1: fold into right half-plane, scale y by sqrt(3)
    hsi_pkg::stage_t st1_reg;
    logic            neg;
    logic [9:0]      ax;
    logic signed [8:0] fy;
    logic signed [hsi_pkg::VEC_W-1:0] y_init;

    assign neg    = dx0_reg[10];
    assign ax     = neg ? 10'(-dx0_reg) : 10'(dx0_reg);
    assign fy     = neg ? -dy0_reg : dy0_reg;
    assign y_init = hsi_pkg::VEC_W'(fy) * $signed({1'b0, hsi_pkg::SQRT3_Q40});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg.valid <= 1'b0;
        end else if (ce) begin
            st1_reg.valid <= v0_reg;
        end
        if (ce) begin
            st1_reg.x     <= $signed({2'b00, ax, 40'd0});
            st1_reg.y     <= y_init;
            st1_reg.acc   <= neg ? 32'h8000_0000 : 32'd0;
            st1_reg.rem   <= {sat_num0_reg, 16'd0} + hsi_pkg::REM_W'(sum0_reg);
            st1_reg.quo   <= '0;
            st1_reg.sum   <= sum0_reg;
            st1_reg.grey  <= grey0_reg;
            st1_reg.black <= (sum0_reg == '0);
        end
    end

    // ---- CORDIC chain
    hsi_pkg::stage_t chain [0:hsi_pkg::CORDIC_N];
    assign chain[0] = st1_reg;

    for (genvar i = 0; i < hsi_pkg::CORDIC_N; i++) begin : g_cordic
        hsi_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .idx       (hsi_pkg::IDX_W'(i)),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    // ---- output: round hue to 16 bits, apply special cases
    hsi_pkg::stage_t          last;
    logic [hsi_pkg::ACC_W-1:0] hue_round;
    logic [hsi_pkg::HUE_W-1:0] hue_next;
    logic [hsi_pkg::SAT_W-1:0] sat_next;
    logic                      out_valid_reg;
    logic [47:0]               out_data_reg;

    assign last      = chain[hsi_pkg::CORDIC_N];
    assign hue_round = last.acc + 32'h0000_8000;
    assign hue_next  = last.grey ? '0 : hue_round[31:16];
    assign sat_next  = last.black ? 16'h8000 : last.quo;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= last.valid;
        end
        if (ce) begin
            out_data_reg <= {6'd0, last.sum, sat_next, hue_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ rtl/rgb_to_hsi_pixel_checker.sv @@
module rgb_to_hsi_pixel_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[31:16] <= 16'h8000
                          && m_axis_tdata[41:32] <= 10'd765)
        else $error("field out of range");

    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[41:32] == 10'd0 |->
            m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[31:16] == 16'h8000)
        else $error("black pixel result wrong");

endmodule

bind rgb_to_hsi_pixel rgb_to_hsi_pixel_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

typedef struct packed {
    logic [hsi_pkg::HUE_W-1:0] hue;
    logic [hsi_pkg::SAT_W-1:0] sat;
    logic [hsi_pkg::SUM_W-1:0] sum;
} hsi_t;

// Holds predicted HSI results in arrival order and checks the block against them.
class hsi_scoreboard;
    hsi_t pending[$];
    int   mismatches;
    int   checked;

    // Hue by CORDIC on the vector (2r-g-b, sqrt3*(g-b)), angle counted in units of 2^-32 turn.
    function logic [hsi_pkg::HUE_W-1:0] hue_of(int dx, int dy);
        logic signed [63:0] x, y, xs, ys;
        logic [31:0] acc;
        logic [31:0] step;
        x = 64'(dx) <<< 40;
        y = 64'(dy) * 64'sd1904410002821;
        acc = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = 32'h8000_0000;
        end
        for (int i = 0; i < 30; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            step = atan_step(i);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                acc = acc + step;
            end else begin
                x = x - ys;
                y = y + xs;
                acc = acc - step;
            end
        end
        acc = acc + 32'h8000;
        return acc[31:16];
    endfunction

    function logic [31:0] atan_step(int i);
        logic [31:0] t [30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
            20, 10, 5, 3, 1};
        return t[i];
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        hsi_t e;
        int sum, mn;
        longint num;
        sum = r + g + b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        if (sum == 0) e.sat = 16'd32768;
        else begin
            num = longint'(sum - 3 * mn) << 16;
            e.sat = 16'((num + sum) / (2 * sum));
        end
        e.sum = 10'(sum);
        // grey (and black) pixels carry no hue
        if (r == g && r == b) e.hue = '0;
        else e.hue = hue_of(2 * int'(r) - int'(g) - int'(b), int'(g) - int'(b));
        pending.push_back(e);
    endfunction

    function void check_result(logic [47:0] d);
        hsi_t e, a;
        a.hue = d[15:0];
        a.sat = d[31:16];
        a.sum = d[41:32];
        checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", d);
            return;
        end
        e = pending.pop_front();
        if (a !== e || d[47:42] !== 6'd0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp hue %0d sat %0d sum %0d, got hue %0d sat %0d sum %0d",
                    e.hue, e.sat, e.sum, a.hue, a.sat, a.sum);
        end
    endfunction
endclass

module testbench;
    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // chan_r[7:0], chan_g[15:8], chan_b[23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // hue_turn, sat_q15, intensity_sum, pad

    hsi_scoreboard board;
    int  cycles;
    int  sent;
    bit  stim_done;
    bit  hold_ready;

    localparam int LIMIT = 200000;

    rgb_to_hsi_pixel uut (.*);

    // 12 ns clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // timeout watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // results sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end

    // receiver: a random stall before each result, none while hold_ready is set
    initial begin
        int w;
        m_axis_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            w = hold_ready ? 0 : $urandom_range(0, 5);
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    // one pixel request; a random gap before it unless burst
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit burst);
        int w;
        w = burst ? 0 : $urandom_range(0, 5);
        if (w > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (w) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        do @(posedge aclk); while (!s_axis_tready);
        board.note_pixel(r, g, b);
        sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
    endtask

    initial begin
        logic [7:0] r, g, b;
        int k;
        board = new();
        sent = 0;
        hold_ready = 0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // directed: black, white, grey, primaries, hue near full-turn wrap
        send_pixel(0, 0, 0, 0);
        send_pixel(255, 255, 255, 0);
        send_pixel(128, 128, 128, 1);
        send_pixel(255, 0, 0, 1);
        send_pixel(0, 255, 0, 0);
        send_pixel(0, 0, 255, 0);
        send_pixel(255, 255, 0, 1);
        send_pixel(0, 255, 255, 0);
        send_pixel(255, 0, 255, 0);
        send_pixel(255, 0, 1, 1);
        send_pixel(255, 1, 0, 0);
        send_pixel(1, 0, 0, 0);
        send_pixel(0, 1, 1, 0);
        send_pixel(255, 254, 255, 1);
        send_pixel(254, 255, 255, 0);
        send_pixel(0, 255, 254, 0);
        send_pixel(100, 50, 51, 0);
        send_pixel(170, 85, 85, 0);
        send_pixel(1, 1, 0, 0);
        send_pixel(0, 0, 1, 0);
        // hold off until the pipe is empty
        drain();

        // random part: mostly uniform, some near-grey and channel extremes
        for (int n = 0; n < 1400; n++) begin
            k = $urandom_range(0, 9);
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            if (k == 0) begin
                g = 8'(r + $urandom_range(0, 2) - 1);
                b = 8'(r + $urandom_range(0, 2) - 1);
            end else if (k == 1) begin
                r = $urandom_range(0, 1) ? 8'hff : 8'h00;
                b = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
            if (n >= 500 && n < 700) hold_ready = 1;
            else hold_ready = 0;
            send_pixel(r, g, b, (n >= 500 && n < 700) || k == 2);
        end
        drain();
        repeat (40) @(negedge aclk);

        $display("covered %0d pixels: black, grey, primaries, hue wrap, random and near-grey",
            sent);
        $display("%0d results checked, %0d mismatches", board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
